FILE: hw/rtl/ptdf_pkg.sv
package ptdf_pkg;

  localparam int unsigned PHASE_BITS = 32;
  localparam int unsigned COORD_BITS = 32;

  localparam int unsigned STEP_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned TAU_W = 17;
  localparam int unsigned PARAM_W = 24;
  localparam int unsigned COEF_W = 26;
  localparam int unsigned THR_W = 18;
  localparam int unsigned THR_FRAC = 17;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [TAU_W-1:0] TAU_ONE = 17'd65536;
  localparam logic [TAU_W-1:0] TAU_RESET = 17'd6554;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_TAU = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PARAM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_PARAM = 2'd2;

  typedef logic signed [1:0] level_t;

  localparam level_t LEVEL_POS = 2'sb01;
  localparam level_t LEVEL_ZERO = 2'sb00;
  localparam level_t LEVEL_NEG = 2'sb11;

endpackage

FILE: hw/rtl/pulsed_trap_drive_and_force_top.sv
// An input transfer is registered in stage one and then in the output register before the result transfer.
// Throughput: one item per cycle while the output is not stalled; the phase accumulator updates on each input transfer.
// Stage one registers level, positions and force coefficients; stage two holds the multiply result.
// Reset clears the phase accumulator, both valid flags and loads the register reset values.
module pulsed_trap_drive_and_force_top #(
  parameter int unsigned PhaseBits = ptdf_pkg::PHASE_BITS,
  parameter int unsigned CoordBits = ptdf_pkg::COORD_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ptdf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ptdf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ptdf_pkg::STEP_W-1:0]          phase_step_i,
  input  logic signed [CoordBits-1:0]          pos_x_i,
  input  logic signed [CoordBits-1:0]          pos_y_i,
  input  logic signed [CoordBits-1:0]          pos_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [1:0]                    drive_level_o,
  output logic signed [CoordBits-1:0]          force_x_o,
  output logic signed [CoordBits-1:0]          force_y_o,
  output logic signed [CoordBits-1:0]          force_z_o
);

  localparam int unsigned ThrFrac = ptdf_pkg::THR_FRAC;
  localparam int unsigned CmpW = ((PhaseBits > ThrFrac) ? PhaseBits : ThrFrac) + 1;
  localparam int unsigned ShPh = (PhaseBits < ThrFrac) ? (ThrFrac - PhaseBits) : 0;
  localparam int unsigned ShTh = (PhaseBits > ThrFrac) ? (PhaseBits - ThrFrac) : 0;
  localparam int unsigned CoefW = ptdf_pkg::COEF_W;
  localparam int unsigned ThrW = ptdf_pkg::THR_W;
  localparam int unsigned ProdW = CoordBits + CoefW;

  logic [ptdf_pkg::TAU_W-1:0]          duty_tau_q;
  logic signed [ptdf_pkg::PARAM_W-1:0] q_param_q;
  logic signed [ptdf_pkg::PARAM_W-1:0] a_param_q;
  logic [PhaseBits-1:0]                phase_acc_q;
  logic [PhaseBits-1:0]                phase_acc_d;

  logic                                s1_valid_q;
  ptdf_pkg::level_t                    s1_level_q;
  logic signed [CoordBits-1:0]         s1_x_q;
  logic signed [CoordBits-1:0]         s1_y_q;
  logic signed [CoordBits-1:0]         s1_z_q;
  logic signed [CoefW-1:0]             s1_cx_q;
  logic signed [CoefW-1:0]             s1_cy_q;
  logic signed [CoefW-1:0]             s1_cz_q;

  logic                                out_valid_q;
  ptdf_pkg::level_t                    drive_level_q;
  logic signed [CoordBits-1:0]         force_x_q;
  logic signed [CoordBits-1:0]         force_y_q;
  logic signed [CoordBits-1:0]         force_z_q;

  logic                                out_en;
  logic                                s1_en;
  logic                                in_xfer;

  logic [PhaseBits+ptdf_pkg::STEP_W-1:0] step_wide;
  logic [CmpW+PhaseBits-1:0]           ph_wide;
  logic [CmpW-1:0]                     ph_cmp;
  logic [ptdf_pkg::TAU_W-1:0]          tau_sat;
  logic [ThrW-1:0]                     thr1;
  logic [ThrW-1:0]                     thr2;
  logic [ThrW-1:0]                     thr3;
  logic [ThrW-1:0]                     thr4;
  logic [CmpW-1:0]                     thr1_cmp;
  logic [CmpW-1:0]                     thr2_cmp;
  logic [CmpW-1:0]                     thr3_cmp;
  logic [CmpW-1:0]                     thr4_cmp;
  ptdf_pkg::level_t                    level_d;

  logic signed [ptdf_pkg::PARAM_W:0]   q2;
  logic signed [CoefW-1:0]             q2_ext;
  logic signed [CoefW-1:0]             a_ext;
  logic signed [CoefW-1:0]             q2h;
  logic signed [CoefW-1:0]             cx_d;
  logic signed [CoefW-1:0]             cy_d;
  logic signed [CoefW-1:0]             cz_d;

  logic signed [ProdW-1:0]             prod_x;
  logic signed [ProdW-1:0]             prod_y;
  logic signed [ProdW-1:0]             prod_z;

  function automatic logic [CmpW-1:0] thr_align(input logic [ThrW-1:0] t);
    logic [CmpW+ThrW-1:0] wide;
    wide = {{CmpW{1'b0}}, t};
    return wide[CmpW-1:0] << ShTh;
  endfunction

  function automatic logic [CoordBits-1:0] scale_sat(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0]   sh;
    logic [ProdW-CoordBits:0]  upper;
    sh = p >>> ptdf_pkg::FRAC_BITS;
    upper = sh[ProdW-1:CoordBits-1];
    if ((&upper) || (~|upper)) begin
      return sh[CoordBits-1:0];
    end else if (sh[ProdW-1]) begin
      return {1'b1, {(CoordBits-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordBits-1){1'b1}}};
    end
  endfunction

  assign out_en = !out_valid_q || !out_stall_i;
  assign s1_en = !s1_valid_q || out_en;
  assign in_stall_o = !s1_en;
  assign in_xfer = in_valid_i && s1_en;

  always_comb begin
    step_wide = {{PhaseBits{1'b0}}, phase_step_i};
    phase_acc_d = phase_acc_q + step_wide[PhaseBits-1:0];
    ph_wide = {{CmpW{1'b0}}, phase_acc_d};
    ph_cmp = ph_wide[CmpW-1:0] << ShPh;

    tau_sat = (duty_tau_q > ptdf_pkg::TAU_ONE) ? ptdf_pkg::TAU_ONE : duty_tau_q;
    thr1 = {1'b0, tau_sat};
    thr2 = {1'b0, ptdf_pkg::TAU_ONE} - thr1;
    thr3 = {1'b0, ptdf_pkg::TAU_ONE} + thr1;
    thr4 = {ptdf_pkg::TAU_ONE, 1'b0} - thr1;
    thr1_cmp = thr_align(thr1);
    thr2_cmp = thr_align(thr2);
    thr3_cmp = thr_align(thr3);
    thr4_cmp = thr_align(thr4);

    if (ph_cmp <= thr1_cmp) begin
      level_d = ptdf_pkg::LEVEL_POS;
    end else if (ph_cmp < thr2_cmp) begin
      level_d = ptdf_pkg::LEVEL_ZERO;
    end else if (ph_cmp < thr3_cmp) begin
      level_d = ptdf_pkg::LEVEL_NEG;
    end else if (ph_cmp < thr4_cmp) begin
      level_d = ptdf_pkg::LEVEL_ZERO;
    end else begin
      level_d = ptdf_pkg::LEVEL_POS;
    end

    q2 = {q_param_q, 1'b0};
    q2_ext = CoefW'(q2);
    a_ext = CoefW'(a_param_q);
    case (level_d)
      ptdf_pkg::LEVEL_POS: q2h = q2_ext;
      ptdf_pkg::LEVEL_NEG: q2h = -q2_ext;
      default:             q2h = '0;
    endcase
    cx_d = q2h - a_ext;
    cy_d = -q2h - a_ext;
    cz_d = a_ext <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_tau_q <= ptdf_pkg::TAU_RESET;
      q_param_q <= '0;
      a_param_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ptdf_pkg::REG_DUTY_TAU: duty_tau_q <= cfg_data_i[ptdf_pkg::TAU_W-1:0];
        ptdf_pkg::REG_Q_PARAM:  q_param_q <= cfg_data_i;
        ptdf_pkg::REG_A_PARAM:  a_param_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_acc_q <= phase_acc_d;
      end
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_level_q <= level_d;
      s1_x_q <= pos_x_i;
      s1_y_q <= pos_y_i;
      s1_z_q <= pos_z_i;
      s1_cx_q <= cx_d;
      s1_cy_q <= cy_d;
      s1_cz_q <= cz_d;
    end
  end

  assign prod_x = ProdW'(s1_x_q) * ProdW'(s1_cx_q);
  assign prod_y = ProdW'(s1_y_q) * ProdW'(s1_cy_q);
  assign prod_z = ProdW'(s1_z_q) * ProdW'(s1_cz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      drive_level_q <= s1_level_q;
      force_x_q <= scale_sat(prod_x);
      force_y_q <= scale_sat(prod_y);
      force_z_q <= scale_sat(prod_z);
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_level_o = drive_level_q;
  assign force_x_o = force_x_q;
  assign force_y_o = force_y_q;
  assign force_z_o = force_z_q;

endmodule

FILE: hw/rtl/ptdf_checker.sv
module ptdf_checker #(
  parameter int unsigned CoordBits = ptdf_pkg::COORD_BITS
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [1:0]               drive_level_o,
  input logic signed [CoordBits-1:0]     force_x_o
);

  // An accepted item reaches the output via stage one unless the output was blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

  // The input side only stalls when the output register is full and blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output could drain");

  // The drive level is always one of the three defined levels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((drive_level_o == ptdf_pkg::LEVEL_POS) ||
                     (drive_level_o == ptdf_pkg::LEVEL_ZERO) ||
                     (drive_level_o == ptdf_pkg::LEVEL_NEG)))
    else $error("invalid drive level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(force_x_o) && $stable(drive_level_o)))
    else $error("stalled result changed");

endmodule

bind pulsed_trap_drive_and_force_top ptdf_checker #(.CoordBits(CoordBits)) u_ptdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drive_level_o (drive_level_o),
  .force_x_o     (force_x_o)
);
